>>> rtl/rltt_pkg.sv
package rltt_pkg;

  localparam int unsigned TRACK_SLOTS = 16;
  localparam int unsigned SLOT_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam logic [31:0] MAX_AGE_RESET = 32'd1000000;

  localparam logic [2:0] ST_MATCHED = 3'd0;
  localparam logic [2:0] ST_CREATED = 3'd1;
  localparam logic [2:0] ST_NOT_LANDMARK = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;
  localparam logic [2:0] ST_REPORT_EMPTY = 3'd5;

  localparam logic MODE_DETECT = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  localparam logic [0:0] REG_MAX_AGE = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [47:0] frame_time;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] radial_speed;
    logic [31:0] signal_to_noise;
    logic [31:0] noise_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] track_id;
    logic [47:0] last_seen;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_speed;
    logic [31:0] out_snr;
    logic [31:0] out_noise;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
    logic [31:0] w5;
  } words_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic        report;
    logic        landmark;
    logic [47:0] now;
    words_t      words;
  } cmd_t;

endpackage

>>> rtl/rltt_front.sv
module rltt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rltt_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output rltt_pkg::cmd_t    cmd_data
);

  // Two-entry queue between the input port and the table engine.
  rltt_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_idx;
  rltt_pkg::cmd_t c;
  logic push_ok, pop_ok;

  always_comb begin
    c.report = (in_data.mode == rltt_pkg::MODE_REPORT);
    c.landmark = (in_data.radial_speed[30:0] == 31'd0);
    c.now = in_data.frame_time;
    c.words = '{in_data.pos_x, in_data.pos_y, in_data.pos_z,
                in_data.radial_speed, in_data.signal_to_noise, in_data.noise_level};
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop_ok = cmd_valid && cmd_take;
  assign cmd_data = q_r[rd_r];
  assign wr_idx = rd_r ^ cnt_r[0];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    rd_nxt = pop_ok ? ~rd_r : rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_idx] <= c;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) in_full |-> cmd_valid)
    else $error("full queue without valid head");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !push_ok) |=> cnt_r == 2'd0)
    else $error("queue filled without a push");

endmodule

>>> rtl/rltt_back.sv
module rltt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        max_age,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  rltt_pkg::cmd_t     cmd_data,
  output logic               out_empty,
  input  logic               out_pop,
  output rltt_pkg::out_item_t out_data
);

  localparam int unsigned N = rltt_pkg::TRACK_SLOTS;
  localparam int unsigned SW = rltt_pkg::SLOT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [N-1:0] valid_r, valid_nxt;
  rltt_pkg::words_t slot_w_r [N];
  logic [47:0] slot_seen_r [N];
  logic [31:0] slot_id_r [N];
  logic [31:0] next_id_r, next_id_nxt;
  rltt_pkg::cmd_t cmd_r;
  logic [N-1:0] live_r;
  logic [N-1:0] scan_r, scan_nxt;
  rltt_pkg::out_item_t obuf_r, obuf_nxt;
  logic ofull_r, ofull_nxt;

  logic [N-1:0] live_c, match_c;
  logic [47:0] diff;
  logic hit, freef;
  logic [SW-1:0] hit_i, free_i, sc_i;
  logic out_free;
  logic wr_en;
  logic [SW-1:0] wr_i;
  logic wr_new;

  assign out_free = !ofull_r || out_pop;
  assign out_empty = !ofull_r;
  assign out_data = obuf_r;
  assign cmd_take = (state_r == S_IDLE);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      diff = cmd_data.now - slot_seen_r[i];
      live_c[i] = valid_r[i] && ($signed(diff) < $signed({16'd0, max_age}));
      match_c[i] = live_r[i] && (slot_w_r[i] == cmd_r.words);
    end
    hit = 1'b0; hit_i = '0; freef = 1'b0; free_i = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match_c[i]) begin
        hit = 1'b1; hit_i = SW'(i);
      end
      if (!live_r[i]) begin
        freef = 1'b1; free_i = SW'(i);
      end
    end
    sc_i = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (scan_r[i]) sc_i = SW'(i);
    end
  end

  function automatic rltt_pkg::out_item_t mk(logic [2:0] st, rltt_pkg::words_t w,
                                             logic [31:0] id, logic [47:0] t, logic l);
    rltt_pkg::out_item_t o;
    o = '{st, id, t, w.w0, w.w1, w.w2, w.w3, w.w4, w.w5, l};
    return o;
  endfunction

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    next_id_nxt = next_id_r;
    scan_nxt = scan_r;
    obuf_nxt = obuf_r;
    ofull_nxt = ofull_r && !out_pop;
    wr_en = 1'b0; wr_i = '0; wr_new = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          valid_nxt = live_c;
          scan_nxt = live_c;
          state_nxt = cmd_data.report ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          ofull_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (!cmd_r.landmark) begin
            obuf_nxt = mk(rltt_pkg::ST_NOT_LANDMARK, '0, '0, '0, 1'b1);
          end else if (hit) begin
            wr_en = 1'b1; wr_i = hit_i;
            obuf_nxt = mk(rltt_pkg::ST_MATCHED, slot_w_r[hit_i], slot_id_r[hit_i],
                          cmd_r.now, 1'b1);
          end else if (freef) begin
            wr_en = 1'b1; wr_i = free_i; wr_new = 1'b1;
            valid_nxt[free_i] = 1'b1;
            next_id_nxt = next_id_r + 32'd1;
            obuf_nxt = mk(rltt_pkg::ST_CREATED, cmd_r.words, next_id_r, cmd_r.now, 1'b1);
          end else begin
            obuf_nxt = mk(rltt_pkg::ST_FULL, '0, '0, '0, 1'b1);
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          ofull_nxt = 1'b1;
          if (scan_r == '0) begin
            obuf_nxt = mk(rltt_pkg::ST_REPORT_EMPTY, '0, '0, '0, 1'b1);
            state_nxt = S_IDLE;
          end else begin
            scan_nxt[sc_i] = 1'b0;
            obuf_nxt = mk(rltt_pkg::ST_REPORT, slot_w_r[sc_i], slot_id_r[sc_i],
                          slot_seen_r[sc_i], (scan_nxt == '0));
            if (scan_nxt == '0) state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      next_id_r <= '0;
      ofull_r <= 1'b0;
      scan_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      next_id_r <= next_id_nxt;
      ofull_r <= ofull_nxt;
      scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obuf_r <= obuf_nxt;
    if (state_r == S_IDLE && cmd_valid) begin
      cmd_r <= cmd_data;
      live_r <= live_c;
    end
    if (wr_en) begin
      slot_seen_r[wr_i] <= cmd_r.now;
      if (wr_new) begin
        slot_w_r[wr_i] <= cmd_r.words;
        slot_id_r[wr_i] <= next_id_r;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC && out_free |=> !out_empty)
    else $error("detection gave no result");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_r & ~valid_r) == '0)
    else $error("report lists a slot that is not valid");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !cmd_take)
    else $error("command taken while busy");

endmodule

>>> rtl/radar_landmark_track_table_unit.sv
// Channel | Direction | Handshake         | Payload
// in_     | in        | in_push / in_full | rltt_pkg::in_item_t
// out_    | out       | out_pop/out_empty | rltt_pkg::out_item_t
// cfg_    | in        | APB write/read    | max_age at address 0
// In the table engine a detection first expires tracks and registers the
// live set, then compares all slots in parallel and writes back once the
// output register is free. A report likewise expires and registers, then
// emits a row per live track in slot order, or one empty row if none is live.
// A two-entry queue lets the input side accept while the engine works, and
// a one-entry output register holds a result while out_pop is low.
// Reset clears all valid bits and the id counter at once; no clearing pass.
module radar_landmark_track_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  rltt_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output rltt_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [1:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [31:0] max_age_r;
  logic cmd_valid, cmd_take;
  rltt_pkg::cmd_t cmd_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == 2'd0) ? max_age_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= rltt_pkg::MAX_AGE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      max_age_r <= cfg_pwdata;
    end
  end

  rltt_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .cmd_valid, .cmd_take, .cmd_data
  );

  rltt_back u_back (
    .clk, .rst_n, .max_age(max_age_r), .cmd_valid, .cmd_take, .cmd_data,
    .out_empty, .out_pop, .out_data
  );

endmodule

>>> bench/tb_top.sv
module tb_top;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  rltt_pkg::in_item_t  in_data;
  logic                out_empty;
  logic                out_pop;
  rltt_pkg::out_item_t out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [1:0]          cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  radar_landmark_track_table_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow copy of the track table.
  logic [31:0]      age_limit;
  logic             trk_valid [rltt_pkg::TRACK_SLOTS];
  rltt_pkg::words_t trk_words [rltt_pkg::TRACK_SLOTS];
  logic [47:0]      trk_seen [rltt_pkg::TRACK_SLOTS];
  logic [31:0]      trk_ident [rltt_pkg::TRACK_SLOTS];
  logic [31:0]      ident_counter;

  rltt_pkg::out_item_t pending_results [$];
  int                  fail_count;
  int                  send_idle;
  int                  recv_stall;
  bit                  push_active;
  logic [47:0]         clock_now;
  rltt_pkg::words_t    word_pool [6];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 600000);
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit track_alive(int s, logic [47:0] now);
    logic [47:0] diff;
    logic signed [63:0] sdiff;
    diff = now - trk_seen[s];
    sdiff = {{16{diff[47]}}, diff};
    return trk_valid[s] && (sdiff < $signed({32'd0, age_limit}));
  endfunction

  function automatic rltt_pkg::out_item_t track_row(logic [2:0] st, int s, logic last);
    rltt_pkg::out_item_t r;
    r = '0;
    r.status = st;
    if (s >= 0) begin
      r.track_id = trk_ident[s];
      r.last_seen = trk_seen[s];
      r.out_x = trk_words[s].w0;
      r.out_y = trk_words[s].w1;
      r.out_z = trk_words[s].w2;
      r.out_speed = trk_words[s].w3;
      r.out_snr = trk_words[s].w4;
      r.out_noise = trk_words[s].w5;
    end
    r.last_of_run = last;
    return r;
  endfunction

  task automatic predict_tracks(rltt_pkg::in_item_t it);
    rltt_pkg::words_t w;
    int n;
    int hit;
    rltt_pkg::out_item_t r;
    for (int s = 0; s < rltt_pkg::TRACK_SLOTS; s++)
      if (!track_alive(s, it.frame_time)) trk_valid[s] = 1'b0;
    if (it.mode == rltt_pkg::MODE_REPORT) begin
      n = 0;
      for (int s = 0; s < rltt_pkg::TRACK_SLOTS; s++)
        if (trk_valid[s]) begin
          pending_results.push_back(track_row(rltt_pkg::ST_REPORT, s, 1'b0));
          n++;
        end
      if (n == 0) begin
        pending_results.push_back(track_row(rltt_pkg::ST_REPORT_EMPTY, -1, 1'b1));
      end else begin
        r = pending_results.pop_back();
        r.last_of_run = 1'b1;
        pending_results.push_back(r);
      end
      return;
    end
    w = {it.pos_x, it.pos_y, it.pos_z, it.radial_speed, it.signal_to_noise, it.noise_level};
    if (w.w3[30:0] != 31'd0) begin
      pending_results.push_back(track_row(rltt_pkg::ST_NOT_LANDMARK, -1, 1'b1));
      return;
    end
    hit = -1;
    for (int s = 0; s < rltt_pkg::TRACK_SLOTS; s++)
      if (hit < 0 && trk_valid[s] && trk_words[s] == w) hit = s;
    if (hit >= 0) begin
      trk_seen[hit] = it.frame_time;
      pending_results.push_back(track_row(rltt_pkg::ST_MATCHED, hit, 1'b1));
      return;
    end
    for (int s = 0; s < rltt_pkg::TRACK_SLOTS; s++)
      if (hit < 0 && !trk_valid[s]) hit = s;
    if (hit >= 0) begin
      trk_valid[hit] = 1'b1;
      trk_words[hit] = w;
      trk_seen[hit] = it.frame_time;
      trk_ident[hit] = ident_counter;
      ident_counter = ident_counter + 32'd1;
      pending_results.push_back(track_row(rltt_pkg::ST_CREATED, hit, 1'b1));
    end else begin
      pending_results.push_back(track_row(rltt_pkg::ST_FULL, -1, 1'b1));
    end
  endtask

  task automatic send_item(rltt_pkg::in_item_t it);
    int gap;
    if (push_active && $urandom_range(99) < send_idle) begin
      gap = $urandom_range(1, 4);
      in_push <= 1'b0;
      push_active = 0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    if (!push_active) in_push <= 1'b1;
    push_active = 1;
    do @(posedge clk); while (in_full);
    predict_tracks(it);
  endtask

  task automatic settle;
    if (push_active) in_push <= 1'b0;
    push_active = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_max_age(logic [31:0] v);
    settle();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {rltt_pkg::REG_MAX_AGE, 1'b0};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    age_limit = v;
  endtask

  function automatic rltt_pkg::in_item_t detection(logic [47:0] t, rltt_pkg::words_t w);
    rltt_pkg::in_item_t it;
    it.mode = rltt_pkg::MODE_DETECT;
    it.frame_time = t;
    {it.pos_x, it.pos_y, it.pos_z, it.radial_speed, it.signal_to_noise, it.noise_level} = w;
    return it;
  endfunction

  function automatic rltt_pkg::in_item_t report(logic [47:0] t);
    rltt_pkg::in_item_t it;
    it = '0;
    it.mode = rltt_pkg::MODE_REPORT;
    it.frame_time = t;
    it.pos_x = $urandom;
    it.noise_level = $urandom;
    return it;
  endfunction

  function automatic rltt_pkg::words_t random_words(bit landmark);
    rltt_pkg::words_t w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (landmark) w.w3 = {1'($urandom_range(1)), 31'd0};
    return w;
  endfunction

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s expected %0h actual %0h", name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transfer with status %0d", out_data.status);
          fail_count++;
        end else begin
          rltt_pkg::out_item_t e;
          e = pending_results.pop_front();
          check_field("status", e.status, out_data.status);
          check_field("track_id", e.track_id, out_data.track_id);
          check_field("last_seen", e.last_seen, out_data.last_seen);
          check_field("out_x", e.out_x, out_data.out_x);
          check_field("out_y", e.out_y, out_data.out_y);
          check_field("out_z", e.out_z, out_data.out_z);
          check_field("out_speed", e.out_speed, out_data.out_speed);
          check_field("out_snr", e.out_snr, out_data.out_snr);
          check_field("out_noise", e.out_noise, out_data.out_noise);
          check_field("last_of_run", e.last_of_run, out_data.last_of_run);
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic test_directed;
    rltt_pkg::words_t w;
    rltt_pkg::words_t first;
    send_item(report(48'd100));
    first = random_words(1'b0);
    first.w3 = 32'h0000_0000;
    send_item(detection(48'd200, first));
    send_item(detection(48'd300, first));
    w = first;
    w.w3 = 32'h8000_0000;
    send_item(detection(48'd300, w));
    w.w3 = 32'h0000_0001;
    send_item(detection(48'd300, w));
    w.w3 = 32'h7FFF_FFFF;
    send_item(detection(48'd300, w));
    send_item(detection(48'd300, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF}));
    send_item(detection(48'd300, '0));
    for (int k = 0; k < 14; k++) send_item(detection(48'd400, random_words(1'b1)));
    send_item(report(48'd400));
    send_item(detection(48'd50, first));
    send_item(report(48'hFFFF_FFFF_FFFF));
    send_item(report(48'hFFFF_FFFF_FFFF));
    write_max_age(32'hFFFF_FFFF);
    send_item(detection(48'd0, first));
    send_item(detection(48'hFFFF_FFFE, first));
    send_item(report(48'h7FFF_FFFF_FFFF));
    write_max_age(32'd1);
    send_item(detection(48'd10, first));
    send_item(detection(48'd10, first));
    send_item(report(48'd11));
  endtask

  task automatic test_random_phase(int items, logic [31:0] age, int idle, int stall);
    rltt_pkg::in_item_t it;
    rltt_pkg::words_t w;
    int r;
    write_max_age(age);
    send_idle = idle;
    recv_stall = stall;
    for (int k = 0; k < 6; k++) word_pool[k] = random_words(1'b1);
    clock_now = 48'({$urandom, $urandom});
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (r < 60) clock_now = clock_now + $urandom_range(0, (age >> 3) + 1);
      else if (r < 70) clock_now = clock_now - $urandom_range(0, 1000);
      else if (r < 75) clock_now = 48'({$urandom, $urandom});
      else if (r < 85) clock_now = clock_now + age - $urandom_range(0, 2);
      if ($urandom_range(9) == 0) begin
        it = report(clock_now);
      end else begin
        r = $urandom_range(99);
        if (r < 45) w = word_pool[$urandom_range(5)];
        else if (r < 85) w = random_words(1'b1);
        else w = random_words(1'b0);
        it = detection(clock_now, w);
      end
      send_item(it);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    fail_count = 0;
    send_idle = 0;
    recv_stall = 0;
    push_active = 0;
    age_limit = rltt_pkg::MAX_AGE_RESET;
    ident_counter = '0;
    for (int s = 0; s < rltt_pkg::TRACK_SLOTS; s++) begin
      trk_valid[s] = 1'b0;
      trk_words[s] = '0;
      trk_seen[s] = '0;
      trk_ident[s] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(75, 32'd1000000, 0, 0);
    test_random_phase(75, 32'd5000, 52, 0);
    test_random_phase(75, 32'hFFFF_FFFF, 0, 52);
    test_random_phase(75, 32'd1, 29, 29);
    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
